FILE: hdl/met_pkg.sv
`timescale 1ns / 1ps
package met_pkg;

  localparam int FRAC = 56;
  localparam int LIMIT_W = 20;
  localparam int DIM_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  // 4.0 in Q7.56, widened by one bit for the carry of x^2 + y^2.
  localparam logic [64:0] ESCAPE_BOUND = 65'h0_0400_0000_0000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN      = 3'd0,
    REG_Y_MIN      = 3'd1,
    REG_X_STEP     = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } pix_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [LIMIT_W-1:0] iterations;
    logic               in_set;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  function automatic logic [7:0] pal_red(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0: v = 8'hFF;
      3'd1: v = 8'hFF;
      3'd2: v = 8'hFF;
      3'd3: v = 8'h00;
      3'd4: v = 8'h00;
      3'd5: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pal_green(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0: v = 8'h00;
      3'd1: v = 8'h77;
      3'd2: v = 8'hFF;
      3'd3: v = 8'hFF;
      3'd4: v = 8'h00;
      3'd5: v = 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pal_blue(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd4: v = 8'hFF;
      3'd5: v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/met_front.sv
`timescale 1ns / 1ps
module met_front #(
  parameter int MAX_DIM = 16384
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [met_pkg::DIM_W-1:0] in_col,
  input  logic [met_pkg::DIM_W-1:0] in_row,
  output logic                      pix_valid,
  output met_pkg::pix_t             pix,
  input  logic                      pix_pop
);
  import met_pkg::*;

  localparam logic [16:0] DIM_LIM = 17'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_TOP = DIM_W'(MAX_DIM - 1);

  pix_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  pix_t       clamped;

  always_comb begin
    clamped.col = ({3'b0, in_col} >= DIM_LIM) ? DIM_TOP : in_col;
    clamped.row = ({3'b0, in_row} >= DIM_LIM) ? DIM_TOP : in_row;
  end

  assign in_full   = (count_r == 2'd2);
  assign do_push   = in_push && !in_full;
  assign pix_valid = (count_r != 2'd0);
  assign pix       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        q_r[wr_ptr_r] <= clamped;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (pix_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(do_push) - 2'(pix_pop);
    end
  end

endmodule

FILE: hdl/met_mul.sv
`timescale 1ns / 1ps
module met_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::mul_req_t req,
  output logic              done,
  output logic [127:0]      prod
);
  import met_pkg::*;

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  logic         busy_r, done_r;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  corr;

  // Four 32x32 partial products, one a cycle, then the signed correction of the high half.
  always_comb begin
    case (step_r[1:0])
      2'd0: begin
        opa = a_r[31:0];
        opb = b_r[31:0];
      end
      2'd1: begin
        opa = a_r[31:0];
        opb = b_r[63:32];
      end
      2'd2: begin
        opa = a_r[63:32];
        opb = b_r[31:0];
      end
      default: begin
        opa = a_r[63:32];
        opb = b_r[63:32];
      end
    endcase
    pp = {32'b0, opa} * {32'b0, opb};
    case (step_r[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
    corr = (a_r[63] ? b_r : 64'd0) + (b_r[63] ? a_r : 64'd0);
  end

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= 128'd0;
        step_r <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r == 3'd4) begin
          acc_r[127:64] <= acc_r[127:64] - corr;
          busy_r        <= 1'b0;
          done_r        <= 1'b1;
        end else begin
          acc_r  <= acc_r + pp_sh;
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

endmodule

FILE: hdl/met_engine.sv
`timescale 1ns / 1ps
module met_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pix_valid,
  input  met_pkg::pix_t               pix,
  output logic                        pix_pop,
  input  logic [63:0]                 x_min,
  input  logic [63:0]                 y_min,
  input  logic [63:0]                 x_step,
  input  logic [63:0]                 y_step,
  input  logic [met_pkg::LIMIT_W-1:0] iter_limit,
  output logic                        res_valid,
  output met_pkg::res_t               res,
  input  logic                        res_ready
);
  import met_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CX, S_CY, S_LOOP, S_SQX, S_SQY, S_TEST, S_XY, S_DONE
  } state_t;

  state_t             state_r;
  logic [DIM_W-1:0]   row_r;
  logic [63:0]        cx_r, cy_r, zx_r, zy_r, xs_r, ys_r;
  logic [LIMIT_W-1:0] iter_r;
  logic [2:0]         k_r;
  res_t               res_r;
  mul_req_t           mreq;
  logic               mul_done;
  logic [127:0]       prod;
  logic               escape;
  logic [63:0]        sq;

  met_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mul_done),
    .prod (prod)
  );

  // A square is never negative, so anything above the Q7.56 range saturates.
  assign sq     = (prod[127:119] != 9'd0) ? Q_MAX : prod[119:56];
  assign escape = ({1'b0, xs_r} + {1'b0, ys_r}) > ESCAPE_BOUND;

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = zx_r;
    mreq.b     = zx_r;
    case (state_r)
      S_IDLE: begin
        mreq.start = pix_valid;
        mreq.a     = {50'b0, pix.col};
        mreq.b     = x_step;
      end
      S_CX: begin
        mreq.start = mul_done;
        mreq.a     = {50'b0, row_r};
        mreq.b     = y_step;
      end
      S_LOOP: begin
        mreq.start = (iter_r != iter_limit);
      end
      S_SQX: begin
        mreq.start = mul_done;
        mreq.a     = zy_r;
        mreq.b     = zy_r;
      end
      S_TEST: begin
        mreq.start = !escape;
        mreq.b     = zy_r;
      end
      default: ;
    endcase
  end

  assign pix_pop   = (state_r == S_IDLE) && pix_valid;
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pix_valid) begin
            row_r   <= pix.row;
            state_r <= S_CX;
          end
        end
        S_CX: begin
          if (mul_done) begin
            cx_r    <= x_min + prod[63:0];
            zx_r    <= x_min + prod[63:0];
            state_r <= S_CY;
          end
        end
        S_CY: begin
          if (mul_done) begin
            cy_r    <= y_min + prod[63:0];
            zy_r    <= y_min + prod[63:0];
            iter_r  <= '0;
            k_r     <= 3'd0;
            state_r <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (iter_r == iter_limit) begin
            res_r.red        <= 8'h00;
            res_r.green      <= 8'h00;
            res_r.blue       <= 8'h00;
            res_r.iterations <= iter_r;
            res_r.in_set     <= 1'b1;
            state_r          <= S_DONE;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          if (mul_done) begin
            xs_r    <= sq;
            state_r <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            ys_r    <= sq;
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (escape) begin
            res_r.red        <= pal_red(k_r);
            res_r.green      <= pal_green(k_r);
            res_r.blue       <= pal_blue(k_r);
            res_r.iterations <= iter_r;
            res_r.in_set     <= 1'b0;
            state_r          <= S_DONE;
          end else begin
            state_r <= S_XY;
          end
        end
        S_XY: begin
          if (mul_done) begin
            zx_r    <= xs_r - ys_r + cx_r;
            zy_r    <= prod[118:55] + cy_r;
            iter_r  <= iter_r + 1'b1;
            k_r     <= (k_r == 3'd5) ? 3'd0 : k_r + 3'd1;
            state_r <= S_LOOP;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_CX || state_r == S_CY || state_r == S_SQX ||
                  state_r == S_SQY || state_r == S_XY))
    else $error("multiplier finished while the engine was not waiting for it");

  a_palette_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (k_r <= 3'd5))
    else $error("palette index out of range");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQX || state_r == S_SQY || state_r == S_TEST || state_r == S_XY)
      |-> (iter_r < iter_limit))
    else $error("iteration count ran past the limit");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid) |-> ($past(state_r) == S_LOOP || $past(state_r) == S_TEST))
    else $error("result raised from an unexpected state");

endmodule

FILE: hdl/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// Escape-time pixel engine in Q7.56 fixed point. A pixel first forms c from two products,
// then iterates z <- z^2 + c, squaring both parts of z and, unless z has escaped, forming
// their cross product, until z escapes or reaches the iteration limit. Every product goes
// through one shared 32x32 multiplier that builds each 64x64 product from four partial
// products plus a sign correction. Two pixels can wait in the input queue and two results
// in the output queue while the engine works on one pixel at a time.
module mandelbrot_escape_time_pixel #(
  parameter int MAX_DIM = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [met_pkg::DIM_W-1:0]     in_col,
  input  logic [met_pkg::DIM_W-1:0]     in_row,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [met_pkg::LIMIT_W-1:0]   out_iterations,
  output logic                          out_in_set,
  input  logic                          cfg_we,
  input  logic [met_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_wdata
);
  import met_pkg::*;

  logic [63:0]        x_min_r, y_min_r, x_step_r, y_step_r;
  logic [LIMIT_W-1:0] iter_limit_r;
  logic               pix_valid, pix_pop;
  pix_t               pix;
  logic               res_valid, res_ready, res_push, res_pop;
  res_t               res;
  res_t               oq_r [2];
  logic               owr_r, ord_r;
  logic [1:0]         ocount_r;
  res_t               head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r      <= 64'd0;
      y_min_r      <= 64'd0;
      x_step_r     <= 64'd0;
      y_step_r     <= 64'd0;
      iter_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN:      x_min_r      <= cfg_wdata;
        REG_Y_MIN:      y_min_r      <= cfg_wdata;
        REG_X_STEP:     x_step_r     <= cfg_wdata;
        REG_Y_STEP:     y_step_r     <= cfg_wdata;
        REG_ITER_LIMIT: iter_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  met_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_col   (in_col),
    .in_row   (in_row),
    .pix_valid(pix_valid),
    .pix      (pix),
    .pix_pop  (pix_pop)
  );

  met_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_pop   (pix_pop),
    .x_min     (x_min_r),
    .y_min     (y_min_r),
    .x_step    (x_step_r),
    .y_step    (y_step_r),
    .iter_limit(iter_limit_r),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Result queue: the engine hands a beat over as soon as there is room.
  assign res_ready = (ocount_r != 2'd2);
  assign res_push  = res_valid && res_ready;
  assign out_empty = (ocount_r == 2'd0);
  assign res_pop   = out_pop && !out_empty;
  assign head      = oq_r[ord_r];

  assign out_red        = head.red;
  assign out_green      = head.green;
  assign out_blue       = head.blue;
  assign out_iterations = head.iterations;
  assign out_in_set     = head.in_set;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r    <= 1'b0;
      ord_r    <= 1'b0;
      ocount_r <= 2'd0;
    end else begin
      if (res_push) begin
        oq_r[owr_r] <= res;
        owr_r       <= ~owr_r;
      end
      if (res_pop) begin
        ord_r <= ~ord_r;
      end
      ocount_r <= ocount_r + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule
